[rtl/core/kdrs_pkg.sv]
// Shared types and constants for the Kerr disk redshift factor core.
`default_nettype none
package kdrs_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ORBIT = 2'd1,
    STATUS_ZERO_DEN = 2'd2
  } status_t;

  // Datapath widths fixed by the fixed-point formats.
  localparam int RAD_W   = 32;  // radius, unsigned Q12.20
  localparam int SQ_W    = 36;  // sqrt(r) in Q.30
  localparam int P15_W   = 48;  // r^1.5 in Q.30
  localparam int D_W     = 50;  // d, N and den, signed Q.30
  localparam int M_W     = 49;  // sqrt(r^1.5 * N) in Q.30
  localparam int UDEN_W  = 50;  // magnitude of den
  localparam int INT_W   = 3;   // integer quotient bits before saturation
  localparam int FRAC_W  = 28;  // fractional bits of g
  localparam int Q_W     = INT_W + FRAC_W;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage
`default_nettype wire

[rtl/core/kdrs_isqrt.sv]
// Pipelined integer square root, one root bit resolved per register stage.
`default_nettype none
module kdrs_isqrt #(
  parameter int RADIC_W = 72,
  parameter int ROOT_W  = 36,
  parameter int SB_W    = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [RADIC_W-1:0] in_radicand,
  input  wire logic [SB_W-1:0]    in_sb,
  output logic                    out_valid,
  output logic [ROOT_W-1:0]       out_root,
  output logic [SB_W-1:0]         out_sb
);

  logic               valid [ROOT_W+1];
  logic [RADIC_W-1:0] rem   [ROOT_W+1];
  logic [ROOT_W-1:0]  root  [ROOT_W+1];
  logic [SB_W-1:0]    sb    [ROOT_W+1];

  // Stage zero is the incoming word.
  assign valid[0] = in_valid;
  assign rem[0]   = in_radicand;
  assign root[0]  = '0;
  assign sb[0]    = in_sb;

  // Each stage tries the next lower root bit against the running remainder.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic [RADIC_W-1:0] trial;
    logic               fits;

    always_comb begin
      trial = ({{(RADIC_W-ROOT_W){1'b0}}, root[i]} << (B + 1))
              | (RADIC_W'(1) << (2 * B));
      fits  = (rem[i] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      rem[i+1]  <= fits ? (rem[i] - trial) : rem[i];
      root[i+1] <= fits ? (root[i] | (ROOT_W'(1) << B)) : root[i];
      sb[i+1]   <= sb[i];
    end
  end

  assign out_valid = valid[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_sb    = sb[ROOT_W];

endmodule
`default_nettype wire

[rtl/core/kdrs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module kdrs_div #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 50,
  parameter int INT_B  = 3,
  parameter int FRAC_B = 28,
  parameter int SB_W   = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic [NUM_W-1:0]        in_num,
  input  wire logic [DEN_W-1:0]        in_den,
  input  wire logic [SB_W-1:0]         in_sb,
  output logic                         out_valid,
  output logic [INT_B+FRAC_B-1:0]      out_quot,
  output logic [SB_W-1:0]              out_sb
);

  localparam int STEPS = INT_B + FRAC_B;
  localparam int REM_W = DEN_W + INT_B + 1;

  logic             valid [STEPS+1];
  logic [REM_W-1:0] rem   [STEPS+1];
  logic [DEN_W-1:0] den   [STEPS+1];
  logic [STEPS-1:0] quot  [STEPS+1];
  logic [SB_W-1:0]  sb    [STEPS+1];

  // The numerator is below 2^INT_B times the divisor when the result is used.
  assign valid[0] = in_valid;
  assign rem[0]   = REM_W'(in_num);
  assign den[0]   = in_den;
  assign quot[0]  = '0;
  assign sb[0]    = in_sb;

  // Integer bits compare against a shifted divisor, fraction bits shift the remainder.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [REM_W-1:0] part;
    logic [REM_W-1:0] dv;
    logic             fits;

    always_comb begin
      if (i < INT_B) begin
        part = rem[i];
        dv   = REM_W'(den[i]) << (INT_B - 1 - i);
      end else begin
        part = rem[i] << 1;
        dv   = REM_W'(den[i]);
      end
      fits = (part >= dv);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      rem[i+1]  <= fits ? (part - dv) : part;
      den[i+1]  <= den[i];
      quot[i+1] <= {quot[i][STEPS-2:0], fits};
      sb[i+1]   <= sb[i];
    end
  end

  assign out_valid = valid[STEPS];
  assign out_quot  = quot[STEPS];
  assign out_sb    = sb[STEPS];

endmodule
`default_nettype wire

[rtl/core/kerr_disk_redshift_factor_core.sv]
// Top level of the Kerr disk redshift factor pipeline.
//
//  channel   signals                         direction  meaning
//  input     start, busy, radius,            in/out     one word per accepted start
//            photon_ang_mom
//  result    done, shift_factor, status      out        one word per input, one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_spin  in/out     spin register write
//
// A new word may enter each cycle. The pipeline holds the 36-stage sqrt(r),
// the 49-stage sqrt(r^1.5*N), the 31-stage divider and seven plain register stages.
// busy is always low and cfg_ready always high; the result side cannot stall.
// Synchronous reset empties the pipeline and sets the spin to zero.
`default_nettype none
module kerr_disk_redshift_factor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] radius,
  input  wire logic signed [31:0] photon_ang_mom,
  output logic             done,
  output logic signed [31:0] shift_factor,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic signed [31:0] cfg_spin
);
  import kdrs_pkg::*;

  localparam int LATENCY = 123;

  logic signed [31:0] spin;

  // Handshake: the pipeline never stalls.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Spin register.
  always_ff @(posedge clk) begin
    if (rst) begin
      spin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      spin <= cfg_spin;
    end
  end

  // Input register.
  logic              s0_valid;
  logic [RAD_W-1:0]  s0_rad;
  logic [31:0]       s0_l;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_rad <= radius;
    s0_l   <= photon_ang_mom;
  end

  // sqrt(r) in Q.30 from radius * 2^40.
  logic              q1_valid;
  logic [SQ_W-1:0]   q1_sq;
  logic [63:0]       q1_sb;
  kdrs_isqrt #(.RADIC_W(72), .ROOT_W(SQ_W), .SB_W(64)) u_sqrt_r (
    .clk(clk), .rst(rst),
    .in_valid(s0_valid), .in_radicand({s0_rad, 40'b0}), .in_sb({s0_rad, s0_l}),
    .out_valid(q1_valid), .out_root(q1_sq), .out_sb(q1_sb)
  );

  // r^1.5 = radius * sqrt(r) / 2^20.
  logic [67:0]       prod1;
  logic              s1_valid;
  logic [P15_W-1:0]  s1_p15;
  logic [SQ_W-1:0]   s1_sq;
  logic              s1_radz;
  logic [31:0]       s1_l;
  always_comb prod1 = 68'(q1_sb[63:32]) * 68'(q1_sq);
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q1_valid;
    end
    s1_p15  <= prod1[67:20];
    s1_sq   <= q1_sq;
    s1_radz <= (q1_sb[63:32] == '0);
    s1_l    <= q1_sb[31:0];
  end

  // d = r^1.5 + a and N = r^1.5 - 3 sqrt(r) + 2a.
  logic signed [D_W-1:0] d_c, n_c;
  always_comb begin
    d_c = $signed(D_W'(s1_p15)) + D_W'(spin);
    n_c = $signed(D_W'(s1_p15)) - $signed(D_W'(s1_sq)) * 3 + (D_W'(spin) <<< 1);
  end
  logic                  s2_valid;
  logic [P15_W-1:0]      s2_p15;
  logic signed [D_W-1:0] s2_d, s2_n;
  logic                  s2_bad;
  logic [31:0]           s2_l;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_p15 <= s1_p15;
    s2_d   <= d_c;
    s2_n   <= n_c;
    s2_bad <= s1_radz || (d_c == '0) || n_c[D_W-1];
    s2_l   <= s1_l;
  end

  // Partial products of r^1.5 * N and the denominator d - l.
  logic                  s3_valid;
  logic [47:0]           s3_ll, s3_hl;
  logic [48:0]           s3_lh, s3_hh;
  logic signed [D_W-1:0] s3_den;
  logic                  s3_dneg, s3_bad;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_ll   <= 48'(s2_p15[23:0])  * 48'(s2_n[23:0]);
    s3_lh   <= 49'(s2_p15[23:0])  * 49'(s2_n[48:24]);
    s3_hl   <= 48'(s2_p15[47:24]) * 48'(s2_n[23:0]);
    s3_hh   <= 49'(s2_p15[47:24]) * 49'(s2_n[48:24]);
    s3_den  <= s2_d - $signed({{(D_W-38){s2_l[31]}}, s2_l, 6'b0});
    s3_dneg <= s2_d[D_W-1];
    s3_bad  <= s2_bad;
  end

  // Sum the partial products; take sign and magnitude of the denominator.
  logic                s4_valid;
  logic [96:0]         s4_prod;
  logic [UDEN_W-1:0]   s4_uden;
  logic                s4_neg, s4_bad, s4_dz;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_prod <= 97'(s3_ll) + (97'(s3_lh) << 24) + (97'(s3_hl) << 24) + (97'(s3_hh) << 48);
    s4_uden <= s3_den[D_W-1] ? UDEN_W'(-s3_den) : UDEN_W'(s3_den);
    s4_neg  <= s3_dneg ^ s3_den[D_W-1];
    s4_bad  <= s3_bad;
    s4_dz   <= (s3_den == '0);
  end

  // M = sqrt(r^1.5 * N).
  logic              q2_valid;
  logic [M_W-1:0]    q2_m;
  logic [UDEN_W+2:0] q2_sb;
  kdrs_isqrt #(.RADIC_W(97), .ROOT_W(M_W), .SB_W(UDEN_W + 3)) u_sqrt_m (
    .clk(clk), .rst(rst),
    .in_valid(s4_valid), .in_radicand(s4_prod), .in_sb({s4_uden, s4_neg, s4_bad, s4_dz}),
    .out_valid(q2_valid), .out_root(q2_m), .out_sb(q2_sb)
  );

  // Saturation check: quotient of at least 2^INT_W.
  logic              s5_valid;
  logic [M_W-1:0]    s5_m;
  logic [UDEN_W-1:0] s5_uden;
  logic              s5_neg, s5_bad, s5_dz, s5_sat;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= q2_valid;
    end
    s5_m    <= q2_m;
    s5_uden <= q2_sb[UDEN_W+2:3];
    s5_neg  <= q2_sb[2];
    s5_bad  <= q2_sb[1];
    s5_dz   <= q2_sb[0];
    s5_sat  <= ((UDEN_W+INT_W)'(q2_m) >= ((UDEN_W+INT_W)'(q2_sb[UDEN_W+2:3]) << INT_W));
  end

  // |g| = M * 2^28 / |den|.
  logic           dv_valid;
  logic [Q_W-1:0] dv_quot;
  logic [3:0]     dv_sb;
  kdrs_div #(.NUM_W(M_W), .DEN_W(UDEN_W), .INT_B(INT_W), .FRAC_B(FRAC_W), .SB_W(4)) u_div (
    .clk(clk), .rst(rst),
    .in_valid(s5_valid), .in_num(s5_m), .in_den(s5_uden),
    .in_sb({s5_neg, s5_bad, s5_dz, s5_sat}),
    .out_valid(dv_valid), .out_quot(dv_quot), .out_sb(dv_sb)
  );

  // Result register: status, saturation and sign.
  logic [31:0] mag;
  status_t     st_c;
  logic [31:0] sf_c;
  always_comb begin
    mag = {1'b0, dv_quot};
    if (dv_sb[2]) begin
      st_c = STATUS_NO_ORBIT;
      sf_c = '0;
    end else if (dv_sb[1]) begin
      st_c = STATUS_ZERO_DEN;
      sf_c = '0;
    end else if (dv_sb[0]) begin
      st_c = STATUS_OK;
      sf_c = dv_sb[3] ? SAT_NEG : SAT_POS;
    end else begin
      st_c = STATUS_OK;
      sf_c = dv_sb[3] ? (32'd0 - mag) : mag;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    shift_factor <= sf_c;
    status       <= st_c;
  end

  // Every accepted word comes out as a done result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted word did not complete on time");

  // No result appears without a matching word accepted earlier.
  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("result without a matching accepted word");

  // Error results carry a zero factor.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STATUS_OK) |-> (shift_factor == '0))
    else $error("nonzero factor with error status");

endmodule
`default_nettype wire

[bench/kerr_disk_redshift_factor_core_test.sv]
// Self-checking testbench for the Kerr disk redshift factor core.
`default_nettype none
module kerr_disk_redshift_factor_core_test;
  import kdrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 123;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] radius = '0;
  logic signed [31:0] photon_ang_mom = '0;
  logic done;
  logic signed [31:0] shift_factor;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [31:0] cfg_spin = '0;

  kerr_disk_redshift_factor_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .radius(radius),
    .photon_ang_mom(photon_ang_mom), .done(done), .shift_factor(shift_factor),
    .status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_spin(cfg_spin)
  );

  always #5 clk = ~clk;

  // One expected result word.
  typedef struct packed {
    logic [31:0] factor;
    status_t     code;
  } redshift_t;

  redshift_t expected_words[$];
  logic signed [31:0] spin_reg = '0;
  int errors = 0;
  int sender_idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Floor square root of a wide unsigned value.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0] y;
    logic [63:0] t;
    y = '0;
    for (int b = 50; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (128'(t) * 128'(t) <= v) y = t;
    end
    return y;
  endfunction

  // Computes the redshift factor and status for one input word.
  function automatic redshift_t redshift_of(input logic [31:0] rad, input logic signed [31:0] l);
    redshift_t res;
    logic [63:0] sq, p15, m, uden, q;
    logic signed [63:0] a, d, n, den, l30;
    logic [127:0] prod;
    logic [127:0] num;
    logic neg;
    res.factor = '0;
    res.code = STATUS_OK;
    a = 64'(spin_reg);
    l30 = 64'(l) * 64;
    sq = floor_sqrt(128'(rad) << 40);
    prod = 128'(rad) * 128'(sq);
    p15 = 64'(prod >> 20);
    d = $signed(p15) + a;
    n = $signed(p15) - 3 * $signed(sq) + 2 * a;
    if (rad == 0 || d == 0 || n < 0) begin
      res.code = STATUS_NO_ORBIT;
      return res;
    end
    m = floor_sqrt(128'(p15) * 128'(n));
    den = d - l30;
    if (den == 0) begin
      res.code = STATUS_ZERO_DEN;
      return res;
    end
    neg = (d < 0) != (den < 0);
    uden = den < 0 ? 64'(-den) : 64'(den);
    q = m / uden;
    if (q >= 8) begin
      res.factor = neg ? SAT_NEG : SAT_POS;
      return res;
    end
    num = (128'(m) << 28) / 128'(uden);
    res.factor = neg ? 32'(-num) : 32'(num);
    return res;
  endfunction

  // Offers one word and waits until it is accepted; start stays high for back-to-back words.
  task automatic send_word(input logic [31:0] rad, input logic signed [31:0] l);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    radius <= rad;
    photon_ang_mom <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(redshift_of(rad, l));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_spin(input logic signed [31:0] v);
    cfg_valid <= 1'b1;
    cfg_spin <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    spin_reg = v;
  endtask

  // Compares each result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", {shift_factor, 30'd0, status}, '0);
      end else begin
        redshift_t w;
        w = expected_words.pop_front();
        if (shift_factor !== w.factor) report_mismatch("shift_factor", shift_factor, w.factor);
        if (status !== w.code) report_mismatch("status", status, w.code);
      end
    end
  end

  // Directed table with known answers where obvious.
  typedef struct {
    logic [31:0] rad;
    logic signed [31:0] l;
    logic known;
    redshift_t want;
  } row_t;

  row_t rows[] = '{
    '{32'd0, 32'sd0, 1'b1, '{32'd0, STATUS_NO_ORBIT}},
    '{32'd0, 32'h7FFF_FFFF, 1'b1, '{32'd0, STATUS_NO_ORBIT}},
    '{32'h0010_0000, 32'sd0, 1'b1, '{32'd0, STATUS_NO_ORBIT}},
    '{32'h0060_0000, 32'sd0, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0300_0000, 32'h0100_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'hFFFF_FFFF, 32'sd0, 1'b0, '{32'd0, STATUS_OK}},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'd0, STATUS_OK}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0400_0000, 32'h0800_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0090_0000, 32'h0800_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0090_0000, 32'h0D00_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0000_0001, 32'sd0, 1'b1, '{32'd0, STATUS_NO_ORBIT}},
    '{32'h0040_0000, 32'h0800_0000, 1'b0, '{32'd0, STATUS_OK}},
    '{32'h0100_0000, 32'h4000_0000, 1'b0, '{32'd0, STATUS_OK}}
  };

  // Picks l so that the denominator d - l is zero when d is a multiple of 64 and l fits.
  function automatic logic signed [31:0] l_at_pole(input logic [31:0] rad);
    logic [63:0] sq, p15;
    logic signed [63:0] d;
    sq = floor_sqrt(128'(rad) << 40);
    p15 = 64'((128'(rad) * 128'(sq)) >> 20);
    d = $signed(p15) + 64'(spin_reg);
    return 32'(d >>> 6);
  endfunction

  task automatic random_words(input int count);
    logic [31:0] rad;
    logic signed [31:0] l;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      // Mostly radii of a few to a few hundred gravitational radii.
      rad = (kind < 6) ? $urandom_range(32'h1000_0000, 32'h0020_0000) : $urandom;
      if (kind == 9) rad = $urandom_range(32'h0040_0000);
      l = (kind < 4) ? $signed($urandom_range(32'h0A00_0000)) - 32'sh0500_0000 : $urandom;
      if (kind == 8) begin
        rad = $urandom_range(32'h0200_0000) << 6 & 32'hFFFF_FFC0;
        l = l_at_pole(rad);
      end
      send_word(rad, l);
    end
  endtask

  initial begin
    logic signed [31:0] spins[5];
    spins = '{32'sh4000_0000, -32'sh4000_0000, 32'sh2000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed rows at reset spin.
    foreach (rows[k]) begin
      send_word(rows[k].rad, rows[k].l);
      if (rows[k].known && expected_words[$] != rows[k].want)
        report_mismatch("table row", expected_words[$], rows[k].want);
    end
    send_word(32'h0100_0000, l_at_pole(32'h0100_0000));
    drain();
    // Random phases across spin settings and sender idling.
    foreach (spins[k]) begin
      write_spin(spins[k]);
      send_word(32'h0100_0000, 32'sd0);
      sender_idle_pct = (k < 2) ? 19 : (k < 4 ? 85 : 0);
      random_words(105);
      drain();
    end
    sender_idle_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
